// File: hw/rtl/wscr_pkg.sv
// wscr_pkg: shared types and constants for the weighted score replacement block
// no dependencies; used by the interfaces, controller, datapath and top level
`timescale 1ns / 1ps

package wscr_pkg;

  localparam int SET_W      = 11;
  localparam int WAY_IN_W   = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;
  localparam int STAMP_W    = 64;
  localparam int SCORE_W    = 13;
  localparam int MOD_K_W    = 4;
  localparam int FREQ_W     = 4;
  localparam int AGE_W      = 8;
  localparam int REUSE_W    = 4;

  localparam logic [FREQ_W-1:0]  FREQ_SAT  = 4'd15;
  localparam logic [FREQ_W-1:0]  FREQ_FILL = 4'd1;
  localparam logic [AGE_W-1:0]   AGE_MAX   = 8'd255;
  localparam logic [REUSE_W-1:0] REUSE_MAX = 4'd15;

  localparam logic [CFG_IDX_W-1:0] CFG_RECENCY   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FREQUENCY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REUSE     = 2'd2;

  localparam logic [CFG_DATA_W-1:0] RECENCY_W_RST   = 4'd2;
  localparam logic [CFG_DATA_W-1:0] FREQUENCY_W_RST = 4'd3;
  localparam logic [CFG_DATA_W-1:0] REUSE_W_RST     = 4'd2;

  localparam logic CMD_QUERY  = 1'b0;
  localparam logic CMD_UPDATE = 1'b1;

  typedef struct packed {
    logic [STAMP_W-1:0] stamp;
    logic [REUSE_W-1:0] reuse;
    logic [AGE_W-1:0]   age;
    logic [FREQ_W-1:0]  freq;
  } way_entry_t;

  localparam way_entry_t ENTRY_RST = '{stamp: '0, reuse: REUSE_MAX, age: AGE_MAX, freq: '0};

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_READ,
    ST_EVAL,
    ST_TREE,
    ST_OUT
  } ctl_state_t;

  typedef struct packed {
    logic accept;
    logic mod_step;
    logic rd_en;
    logic upd_wr;
    logic clr_wr;
    logic load_leaves;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic is_query;
    logic mod_last;
    logic clr_last;
  } dp_status_t;

endpackage

// File: hw/rtl/wscr_if.sv
// wscr channel interfaces: command items, victim items and register writes
// depends on wscr_pkg for field widths
`timescale 1ns / 1ps

interface wscr_req_if;
  logic                        valid;
  logic                        ready;
  logic                        cmd;
  logic [wscr_pkg::SET_W-1:0]    set_index;
  logic [wscr_pkg::WAY_IN_W-1:0] way_index;
  logic                        was_hit;

  modport source (output valid, cmd, set_index, way_index, was_hit, input ready);
  modport sink (input valid, cmd, set_index, way_index, was_hit, output ready);
endinterface

interface wscr_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [wscr_pkg::WAY_IN_W-1:0] victim_way;

  modport source (output valid, victim_way, input ready);
  modport sink (input valid, victim_way, output ready);
endinterface

interface wscr_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [wscr_pkg::CFG_IDX_W-1:0]  index;
  logic [wscr_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: hw/rtl/wscr_ram.sv
// wscr_ram: generic simple dual port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module wscr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic                                  rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hw/rtl/wscr_ctrl.sv
// wscr_ctrl: sequencing state machine for clear, set reduction, read, update and victim search
// depends on wscr_pkg; drives the datapath by command struct, reads its status struct
`timescale 1ns / 1ps

module wscr_ctrl #(
  parameter int NUM_SETS = 2048,
  parameter int NUM_WAYS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  input  wscr_pkg::dp_status_t status,
  output wscr_pkg::dp_cmd_t    cmd
);

  localparam int LEVELS   = $clog2(NUM_WAYS);
  localparam int TW       = $clog2(LEVELS + 1);
  localparam bit NEED_MOD = (NUM_SETS < (1 << wscr_pkg::SET_W)) &&
                            ((NUM_SETS & (NUM_SETS - 1)) != 0);

  wscr_pkg::ctl_state_t state, state_next;
  logic [TW-1:0]        tree_cnt;
  logic                 out_free;

  assign out_free = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= wscr_pkg::ST_CLEAR;
      tree_cnt  <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == wscr_pkg::ST_TREE) begin
        tree_cnt <= tree_cnt + 1'b1;
      end else begin
        tree_cnt <= '0;
      end
      if (cmd.load_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      wscr_pkg::ST_CLEAR: begin
        if (status.clr_last) state_next = wscr_pkg::ST_IDLE;
      end
      wscr_pkg::ST_IDLE: begin
        if (req_valid) state_next = NEED_MOD ? wscr_pkg::ST_MOD : wscr_pkg::ST_READ;
      end
      wscr_pkg::ST_MOD: begin
        if (status.mod_last) state_next = wscr_pkg::ST_READ;
      end
      wscr_pkg::ST_READ: begin
        state_next = wscr_pkg::ST_EVAL;
      end
      wscr_pkg::ST_EVAL: begin
        state_next = status.is_query ? wscr_pkg::ST_TREE : wscr_pkg::ST_IDLE;
      end
      wscr_pkg::ST_TREE: begin
        if (tree_cnt == TW'(LEVELS - 1)) state_next = wscr_pkg::ST_OUT;
      end
      wscr_pkg::ST_OUT: begin
        if (out_free) state_next = wscr_pkg::ST_IDLE;
      end
      default: begin
        state_next = wscr_pkg::ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    req_ready       = (state == wscr_pkg::ST_IDLE);
    cmd             = '0;
    cmd.accept      = (state == wscr_pkg::ST_IDLE) && req_valid;
    cmd.mod_step    = (state == wscr_pkg::ST_MOD);
    cmd.rd_en       = (state == wscr_pkg::ST_READ);
    cmd.clr_wr      = (state == wscr_pkg::ST_CLEAR);
    cmd.upd_wr      = (state == wscr_pkg::ST_EVAL) && !status.is_query;
    cmd.load_leaves = (state == wscr_pkg::ST_EVAL) && status.is_query;
    cmd.load_out    = (state == wscr_pkg::ST_OUT) && out_free;
  end

endmodule

// File: hw/rtl/wscr_dp.sv
// wscr_dp: weight registers, global clock, set reduction, row store, update logic
// and registered comparison tree; depends on wscr_pkg and wscr_ram
`timescale 1ns / 1ps

module wscr_dp #(
  parameter int NUM_SETS = 2048,
  parameter int NUM_WAYS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  wscr_pkg::dp_cmd_t                    cmd,
  output wscr_pkg::dp_status_t                 status,
  input  logic                                 req_cmd,
  input  logic [wscr_pkg::SET_W-1:0]           req_set_index,
  input  logic [wscr_pkg::WAY_IN_W-1:0]        req_way_index,
  input  logic                                 req_was_hit,
  output logic [wscr_pkg::WAY_IN_W-1:0]        victim_way,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [wscr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [wscr_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int SET_W    = wscr_pkg::SET_W;
  localparam int AW       = NUM_SETS > 1 ? $clog2(NUM_SETS) : 1;
  localparam int XW       = AW > SET_W ? AW : SET_W;
  localparam int DW       = 2 * SET_W;
  localparam int WW       = $clog2(NUM_WAYS);
  localparam int XWW      = WW > wscr_pkg::WAY_IN_W ? WW : wscr_pkg::WAY_IN_W;
  localparam int P        = 1 << WW;
  localparam int NODES    = 2 * P - 1;
  localparam int EW       = $bits(wscr_pkg::way_entry_t);
  localparam int ROW_W    = NUM_WAYS * EW;
  localparam int SCORE_W  = wscr_pkg::SCORE_W;
  localparam bit NEED_MOD = (NUM_SETS < (1 << SET_W)) && ((NUM_SETS & (NUM_SETS - 1)) != 0);
  localparam logic [SET_W-1:0] SET_MASK =
    (NEED_MOD || NUM_SETS >= (1 << SET_W)) ? {SET_W{1'b1}} : SET_W'(NUM_SETS - 1);

  typedef wscr_pkg::way_entry_t [NUM_WAYS-1:0] row_t;

  logic [wscr_pkg::CFG_DATA_W-1:0] rec_w, frq_w, reu_w;
  logic [wscr_pkg::STAMP_W-1:0]    gclk;
  logic                            cmd_q, hit_q;
  logic [wscr_pkg::WAY_IN_W-1:0]   way_q;
  logic [SET_W-1:0]                set_red;
  logic [wscr_pkg::MOD_K_W-1:0]    mod_k;
  logic [DW-1:0]                   div_sh;
  logic                            mod_ge;
  logic [AW-1:0]                   clr_addr;
  logic [XW-1:0]                   set_ext;
  logic [AW-1:0]                   set_addr;

  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  row_t             wr_row, rd_row, upd_row, rst_row;
  logic [ROW_W-1:0] rd_data;

  logic [11:0]                prod_r [NUM_WAYS];
  logic [7:0]                 prod_f [NUM_WAYS];
  logic [7:0]                 prod_u [NUM_WAYS];
  logic signed [SCORE_W-1:0]  leaf_score [NUM_WAYS];

  logic signed [SCORE_W-1:0]     node_score [NODES];
  logic [wscr_pkg::STAMP_W-1:0]  node_stamp [NODES];
  logic [WW-1:0]                 node_way   [NODES];
  logic                          node_valid [NODES];
  logic [XWW-1:0]                root_way_ext;

  // weight registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_w <= wscr_pkg::RECENCY_W_RST;
      frq_w <= wscr_pkg::FREQUENCY_W_RST;
      reu_w <= wscr_pkg::REUSE_W_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        wscr_pkg::CFG_RECENCY:   rec_w <= cfg_data;
        wscr_pkg::CFG_FREQUENCY: frq_w <= cfg_data;
        wscr_pkg::CFG_REUSE:     reu_w <= cfg_data;
        default: ;
      endcase
    end
  end

  // command latch, global clock, clear sweep, set reduction
  assign div_sh = DW'(NUM_SETS) << mod_k;
  assign mod_ge = DW'(set_red) >= div_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      gclk     <= '0;
      clr_addr <= '0;
    end else begin
      if (cmd.accept) gclk <= gclk + 64'd1;
      if (cmd.clr_wr) clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cmd_q   <= req_cmd;
      way_q   <= req_way_index;
      hit_q   <= req_was_hit;
      set_red <= req_set_index & SET_MASK;
      mod_k   <= wscr_pkg::MOD_K_W'(SET_W - 1);
    end else if (cmd.mod_step) begin
      if (mod_ge) set_red <= set_red - div_sh[SET_W-1:0];
      mod_k <= mod_k - 1'b1;
    end
  end

  assign status.is_query = (cmd_q == wscr_pkg::CMD_QUERY);
  assign status.mod_last = (mod_k == '0);
  assign status.clr_last = (clr_addr == AW'(NUM_SETS - 1));

  assign set_ext  = XW'(set_red);
  assign set_addr = set_ext[AW-1:0];

  // row store
  always_comb begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      rst_row[w] = wscr_pkg::ENTRY_RST;
    end
  end

  assign rd_row  = rd_data;
  assign wr_en   = cmd.clr_wr || cmd.upd_wr;
  assign wr_addr = cmd.clr_wr ? clr_addr : set_addr;
  assign wr_row  = cmd.clr_wr ? rst_row : upd_row;

  wscr_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_SETS)
  ) u_row_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_row),
    .rd_en   (cmd.rd_en),
    .rd_addr (set_addr),
    .rd_data (rd_data)
  );

  // access update of one row
  always_comb begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      upd_row[w] = rd_row[w];
      if (32'(way_q) == w) begin
        upd_row[w].age   = '0;
        upd_row[w].stamp = gclk;
        if (hit_q) begin
          if (rd_row[w].freq != wscr_pkg::FREQ_SAT) upd_row[w].freq = rd_row[w].freq + 1'b1;
          upd_row[w].reuse = rd_row[w].reuse >> 1;
        end else begin
          upd_row[w].freq  = wscr_pkg::FREQ_FILL;
          upd_row[w].reuse = wscr_pkg::REUSE_MAX;
        end
      end else if (rd_row[w].age != wscr_pkg::AGE_MAX) begin
        upd_row[w].age = rd_row[w].age + 1'b1;
      end
    end
  end

  // per-way score lanes
  always_comb begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      prod_r[w]     = 12'(rec_w) * 12'(rd_row[w].age);
      prod_f[w]     = 8'(frq_w) * 8'(rd_row[w].freq);
      prod_u[w]     = 8'(reu_w) * 8'(rd_row[w].reuse);
      leaf_score[w] = SCORE_W'(prod_r[w]) + SCORE_W'(prod_u[w]) - SCORE_W'(prod_f[w]);
    end
  end

  // registered min tree, lower ways left; score ties: older stamp, then left side
  always_ff @(posedge clk) begin
    if (cmd.load_leaves) begin
      for (int w = 0; w < P; w++) begin
        node_way[P - 1 + w] <= WW'(w);
        if (w < NUM_WAYS) begin
          node_score[P - 1 + w] <= leaf_score[w];
          node_stamp[P - 1 + w] <= rd_row[w].stamp;
          node_valid[P - 1 + w] <= 1'b1;
        end else begin
          node_score[P - 1 + w] <= '0;
          node_stamp[P - 1 + w] <= '0;
          node_valid[P - 1 + w] <= 1'b0;
        end
      end
    end
    for (int i = 0; i < P - 1; i++) begin
      if (node_valid[2*i+2] &&
          ((node_score[2*i+2] < node_score[2*i+1]) ||
           ((node_score[2*i+2] == node_score[2*i+1]) &&
            (node_stamp[2*i+2] < node_stamp[2*i+1])))) begin
        node_score[i] <= node_score[2*i+2];
        node_stamp[i] <= node_stamp[2*i+2];
        node_way[i]   <= node_way[2*i+2];
      end else begin
        node_score[i] <= node_score[2*i+1];
        node_stamp[i] <= node_stamp[2*i+1];
        node_way[i]   <= node_way[2*i+1];
      end
      node_valid[i] <= node_valid[2*i+1];
    end
  end

  assign root_way_ext = XWW'(node_way[0]);

  always_ff @(posedge clk) begin
    if (cmd.load_out) victim_way <= root_way_ext[wscr_pkg::WAY_IN_W-1:0];
  end

endmodule

// File: hw/rtl/weighted_score_cache_replacement.sv
// weighted_score_cache_replacement: top level, joins controller and datapath
// depends on wscr_pkg, wscr_if, wscr_ctrl, wscr_dp
`timescale 1ns / 1ps

// Replacement policy for a set-associative cache with NUM_SETS sets of NUM_WAYS ways.
// req carries one command item: cmd query (victim search) or update (access of a way).
// rsp carries one victim_way item per query; updates give no item.
// cfg writes the recency, frequency and reuse weights, always ready, one per cycle.
// Each item is handled alone: an update steps through accept, row read and write back;
// a query through accept, row read, score lanes, the levels of the comparison tree and
// result load, bound by the single row memory port.
// When NUM_SETS is not a power of two and below 2048, set reduction runs between accept and row read.
// The result register sits after the tree: req is taken again while a victim item waits
// on rsp; a query that finishes while rsp is still stalled holds until it drains.
// After reset the row memory is cleared one set per cycle over all sets, with req
// held not ready; cfg writes are taken during the sweep. Weights reset to 2, 3 and 2.

module weighted_score_cache_replacement #(
  parameter int NUM_SETS = 2048,
  parameter int NUM_WAYS = 16
) (
  input  logic       clk,
  input  logic       rst,
  wscr_req_if.sink   req,
  wscr_rsp_if.source rsp,
  wscr_cfg_if.sink   cfg
);

  wscr_pkg::dp_cmd_t    dp_cmd;
  wscr_pkg::dp_status_t dp_status;

  wscr_ctrl #(
    .NUM_SETS (NUM_SETS),
    .NUM_WAYS (NUM_WAYS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .status    (dp_status),
    .cmd       (dp_cmd)
  );

  wscr_dp #(
    .NUM_SETS (NUM_SETS),
    .NUM_WAYS (NUM_WAYS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (dp_cmd),
    .status        (dp_status),
    .req_cmd       (req.cmd),
    .req_set_index (req.set_index),
    .req_way_index (req.way_index),
    .req_was_hit   (req.was_hit),
    .victim_way    (rsp.victim_way),
    .cfg_valid     (cfg.valid),
    .cfg_ready     (cfg.ready),
    .cfg_index     (cfg.index),
    .cfg_data      (cfg.data)
  );

endmodule
